### sv/dlr_pkg.sv
`timescale 1ns / 1ps

package dlr_pkg;

    // Field widths of the input and result words.
    localparam int ADDR_W  = 7;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 36;
    localparam int ACT_W   = 31;
    localparam int NIDX_W  = 3;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    // Opcode carried on s_tuser.
    typedef enum logic [0:0] {
        OP_LOAD    = 1'b0,
        OP_FEATURE = 1'b1
    } op_t;

    // Control that the top level broadcasts to every neuron lane.
    typedef struct packed {
        logic load;     // weight write this cycle
        logic rd_en;    // feature accepted: read this element's weight
        logic mul_en;   // weight and feature are ready to multiply
        logic acc_en;   // product is ready to accumulate
        logic acc_clr;  // the product closes a vector
    } lane_ctrl_t;

endpackage

### sv/dlr_lane.sv
`timescale 1ns / 1ps

module dlr_lane
    import dlr_pkg::*;
#(
    parameter int VECTOR_LENGTH = 16,
    parameter int LANE          = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lane_ctrl_t              ctrl,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic signed [VAL_W-1:0] wr_value,
    input  logic [(VECTOR_LENGTH > 1 ? $clog2(VECTOR_LENGTH) : 1)-1:0] rd_elem,
    input  logic signed [VAL_W-1:0] feat_value,
    output logic [ACT_W-1:0]        act
);

    localparam int EW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
    localparam int LO = LANE * VECTOR_LENGTH;
    localparam int HI = (LANE + 1) * VECTOR_LENGTH;
    localparam int BW = $clog2(HI + 1);
    localparam int CW = ((BW > ADDR_W) ? BW : ADDR_W) + 1;

    logic signed [VAL_W-1:0]  mem [VECTOR_LENGTH];
    logic signed [VAL_W-1:0]  weight_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W-1:0]  sum_sat;
    logic [CW-1:0]            addr_ext;
    logic [CW-1:0]            offset;
    logic                     hit;

    // Decode whether a load falls in this neuron's row of weights.
    assign addr_ext = CW'(wr_addr);
    assign hit      = (addr_ext >= CW'(LO)) && (addr_ext < CW'(HI));
    assign offset   = addr_ext - CW'(LO);

    // Weight bank: one write port for loads, one registered read for features.
    always_ff @(posedge aclk) begin
        if (ctrl.load && hit) begin
            mem[offset[EW-1:0]] <= wr_value;
        end
        if (ctrl.rd_en) begin
            weight_reg <= mem[rd_elem];
        end
    end

    // Product of the weight and the feature element, Q8.8 times Q8.8.
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= weight_reg * feat_value;
        end
    end

    // Saturating accumulate at the signed accumulator bounds.
    always_comb begin
        sum = {acc_reg[ACC_W-1], acc_reg}
            + {{(ACC_W + 1 - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        if (sum[ACC_W:ACC_W-1] == 2'b01) begin
            sum_sat = {1'b0, {(ACC_W - 1){1'b1}}};
        end else if (sum[ACC_W:ACC_W-1] == 2'b10) begin
            sum_sat = {1'b1, {(ACC_W - 1){1'b0}}};
        end else begin
            sum_sat = sum[ACC_W-1:0];
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.acc_en) begin
            acc_next = ctrl.acc_clr ? '0 : sum_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    // ReLU with saturation at the top of the Q16.16 range.
    always_comb begin
        if (sum_sat[ACC_W-1]) begin
            act = '0;
        end else if (|sum_sat[ACC_W-2:ACT_W]) begin
            act = '1;
        end else begin
            act = sum_sat[ACT_W-1:0];
        end
    end

endmodule

### sv/dlr_out.sv
`timescale 1ns / 1ps

module dlr_out
    import dlr_pkg::*;
#(
    parameter int NEURON_COUNT = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                capture,
    input  logic [NEURON_COUNT-1:0][ACT_W-1:0]  act,
    output logic                                busy,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [M_DATA_W-1:0]                 m_tdata,
    output logic                                m_tlast
);

    localparam int IW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;

    logic [NEURON_COUNT-1:0][ACT_W-1:0] snap_reg;
    logic [IW-1:0]                      idx_reg;
    logic [IW-1:0]                      idx_next;
    logic                               busy_reg;
    logic                               busy_next;
    logic [IW+NIDX_W-1:0]               idx_ext;
    logic                               at_end;
    logic                               fire;

    assign at_end = (idx_reg == IW'(NEURON_COUNT - 1));
    assign fire   = busy_reg && m_tready;

    // Snapshot of every lane's activation at the end of a vector.
    always_ff @(posedge aclk) begin
        if (capture) begin
            snap_reg <= act;
        end
    end

    // Drain the snapshot one neuron per word.
    always_comb begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (capture) begin
            idx_next  = '0;
            busy_next = 1'b1;
        end else if (fire) begin
            if (at_end) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    assign idx_ext  = {{NIDX_W{1'b0}}, idx_reg};
    assign busy     = busy_reg;
    assign m_tvalid = busy_reg;
    assign m_tlast  = at_end;
    assign m_tdata  = {{(M_DATA_W - ACT_W - NIDX_W){1'b0}}, snap_reg[idx_reg],
                       idx_ext[NIDX_W-1:0]};

endmodule

### sv/dense_layer_relu_core.sv
`timescale 1ns / 1ps

// Fully connected layer with ReLU. Input words with s_tuser low load one Q8.8
// weight at address neuron*VECTOR_LENGTH+element (addresses past the table are
// dropped); words with s_tuser high carry one Q8.8 feature element. Each
// neuron has its own weight bank and accumulator, so one word is taken every
// cycle: the bank is read when the element is accepted, then the product is
// registered, and after that the product is accumulated. On the last
// element of a vector the lanes' activations are snapshotted and sent as
// NEURON_COUNT result words, one per cycle while m_tready is high, starting
// once the snapshot is registered; tlast marks the final neuron. The snapshot
// register is single, so the final element of the next vector waits
// (s_tready low) while the previous vector's results are still draining;
// with VECTOR_LENGTH >= NEURON_COUNT + 3 and no output stall this never
// happens. Weights read before written give arbitrary results.
module dense_layer_relu_core
    import dlr_pkg::*;
#(
    parameter int VECTOR_LENGTH = 16,
    parameter int NEURON_COUNT  = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // weight_address[6:0], value[22:7]
    input  logic                s_tuser,   // opcode[0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // neuron_index[2:0], activation[33:3]
    output logic                m_tlast
);

    localparam int EW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;

    logic                               s_fire;
    logic                               feat_fire;
    logic                               pos_last;
    logic [EW-1:0]                      pos_reg;
    logic [EW-1:0]                      pos_next;
    logic                               s1_valid_reg;
    logic                               s1_last_reg;
    logic                               s2_valid_reg;
    logic                               s2_last_reg;
    logic signed [VAL_W-1:0]            feat_reg;
    logic [ADDR_W-1:0]                  in_addr;
    logic signed [VAL_W-1:0]            in_value;
    op_t                                in_op;
    lane_ctrl_t                         ctrl;
    logic [NEURON_COUNT-1:0][ACT_W-1:0] acts;
    logic                               out_busy;
    logic                               capture;

    assign in_addr  = s_tdata[ADDR_W-1:0];
    assign in_value = s_tdata[ADDR_W+VAL_W-1:ADDR_W];
    assign in_op    = op_t'(s_tuser);
    assign pos_last = (pos_reg == EW'(VECTOR_LENGTH - 1));

    // Hold off only when the next element closes a vector and results are pending.
    assign s_tready  = !(pos_last && (s1_last_reg || s2_last_reg || out_busy));
    assign s_fire    = s_tvalid && s_tready;
    assign feat_fire = s_fire && (in_op == OP_FEATURE);

    // Element position within the current vector.
    always_comb begin
        pos_next = pos_reg;
        if (feat_fire) begin
            pos_next = pos_last ? '0 : pos_reg + 1'b1;
        end
    end

    // Element position, and pipeline valid flags for the multiply and accumulate steps.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            s1_valid_reg <= feat_fire;
            s1_last_reg  <= feat_fire && pos_last;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // The feature element is registered on acceptance and meets its weights in the cycle after.
    always_ff @(posedge aclk) begin
        if (feat_fire) begin
            feat_reg <= in_value;
        end
    end

    always_comb begin
        ctrl.load    = s_fire && (in_op == OP_LOAD);
        ctrl.rd_en   = feat_fire;
        ctrl.mul_en  = s1_valid_reg;
        ctrl.acc_en  = s2_valid_reg;
        ctrl.acc_clr = s2_last_reg;
    end

    assign capture = s2_valid_reg && s2_last_reg;

    // One lane per neuron.
    for (genvar n = 0; n < NEURON_COUNT; n++) begin : g_lane
        dlr_lane #(
            .VECTOR_LENGTH (VECTOR_LENGTH),
            .LANE          (n)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .wr_addr    (in_addr),
            .wr_value   (in_value),
            .rd_elem    (pos_reg),
            .feat_value (feat_reg),
            .act        (acts[n])
        );
    end

    dlr_out #(
        .NEURON_COUNT (NEURON_COUNT)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .capture  (capture),
        .act      (acts),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A vector's results never land on a snapshot that is still draining.
    a_capture_free: assert property (@(posedge aclk) disable iff (!aresetn)
        capture |-> !out_busy)
        else $error("vector end while results still pending");

    // The input stalls only in front of a vector's final element.
    a_stall_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> pos_last)
        else $error("input stalled away from a vector end");

    // After the final neuron word, no further word follows at once.
    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("result words continue past the final neuron");

    // At most one vector end is in flight between acceptance and snapshot.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s1_last_reg && s2_last_reg))
        else $error("two vector ends in flight");

endmodule

### sim/dense_layer_relu_core_test.sv
`timescale 1ns / 1ps

module dense_layer_relu_core_test;
    import dlr_pkg::*;

    localparam int VECTOR_LENGTH = 16;
    localparam int NEURON_COUNT  = 8;
    localparam int WEIGHT_DEPTH  = VECTOR_LENGTH * NEURON_COUNT;
    localparam int RANDOM_WORDS  = 120;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 600;
    localparam int HOLD_AFTER    = 24;
    localparam longint SUM_MAX   = 64'sd34359738367;
    localparam longint SUM_MIN   = -SUM_MAX - 1;
    localparam longint ACT_MAX   = 64'sd2147483647;

    // One activation word as it leaves the block.
    typedef struct packed {
        logic [NIDX_W-1:0] idx;
        logic [ACT_W-1:0]  act;
        logic              last;
    } act_word_t;

    // Directed stimulus: a whole weight table fill, a single load, or a run of
    // identical feature elements, with an optional typed activation for all neurons.
    typedef enum logic [1:0] {
        ROW_FILL,
        ROW_LOAD,
        ROW_FEAT
    } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0] val;
        int               count;
        bit               fixed;
        logic [ACT_W-1:0] fixed_act;
    } plan_row_t;

    localparam int PLAN_ROWS = 7;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    // Predictor state: weight table, per-neuron sums and element position.
    logic signed [VAL_W-1:0] wt_table [WEIGHT_DEPTH];
    longint                  neuron_sum [NEURON_COUNT];
    int                      elem_pos;
    act_word_t               act_expected [$];

    plan_row_t plan [PLAN_ROWS];
    int        fail_count = 0;
    int        results_seen = 0;
    int        cycle_count = 0;
    bit        send_burst;
    bit        recv_burst = 1'b0;
    bit        hold_done = 1'b0;
    act_word_t want;
    act_word_t got;

    dense_layer_relu_core #(
        .VECTOR_LENGTH(VECTOR_LENGTH),
        .NEURON_COUNT (NEURON_COUNT)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // Clock with an 8 ns period.
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Run length guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Updates the predictor with one accepted word and queues the activations
    // it causes. A typed activation, where given, replaces the predicted one.
    task automatic apply_word(input op_t op, input logic [ADDR_W-1:0] addr,
                              input logic signed [VAL_W-1:0] val, input bit fixed,
                              input logic [ACT_W-1:0] fixed_act);
        longint    prod;
        longint    s;
        longint    a;
        act_word_t w;
        if (op == OP_LOAD) begin
            if (addr < WEIGHT_DEPTH)
                wt_table[addr] = val;
        end else begin
            for (int n = 0; n < NEURON_COUNT; n++) begin
                prod = longint'(wt_table[n * VECTOR_LENGTH + elem_pos]) * longint'(val);
                s = neuron_sum[n] + prod;
                if (s > SUM_MAX)
                    s = SUM_MAX;
                else if (s < SUM_MIN)
                    s = SUM_MIN;
                neuron_sum[n] = s;
            end
            elem_pos++;
            // The last element of a vector releases one ReLU word per neuron.
            if (elem_pos == VECTOR_LENGTH) begin
                for (int n = 0; n < NEURON_COUNT; n++) begin
                    s = neuron_sum[n];
                    a = (s < 0) ? 0 : ((s > ACT_MAX) ? ACT_MAX : s);
                    w.idx  = NIDX_W'(n);
                    w.act  = fixed ? fixed_act : ACT_W'(a);
                    w.last = (n == NEURON_COUNT - 1);
                    act_expected.push_back(w);
                    neuron_sum[n] = 0;
                end
                elem_pos = 0;
            end
        end
    endtask

    // Offers one word after a random gap and waits until it is taken.
    task automatic send_word(input op_t op, input logic [ADDR_W-1:0] addr,
                             input logic [VAL_W-1:0] val, input bit fixed,
                             input logic [ACT_W-1:0] fixed_act);
        int gap;
        if ($urandom_range(0, 31) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {1'b0, val, addr};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        apply_word(op, addr, val, fixed, fixed_act);
    endtask

    // Lowers valid and waits until every queued activation has arrived.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (act_expected.size() != 0)
            @(posedge aclk);
    endtask

    // Feature and weight values lean toward the extremes now and then.
    function automatic logic [VAL_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return VAL_W'($urandom_range(0, 511)) - 16'd256;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic void note_fail(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("Mismatch at %0t: %s", $realtime, what);
    endfunction

    // Compare each accepted activation word with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got.idx  = m_tdata[NIDX_W-1:0];
            got.act  = m_tdata[NIDX_W +: ACT_W];
            got.last = m_tlast;
            if (act_expected.size() == 0) begin
                note_fail($sformatf("unexpected word idx %0d act %0d last %0b",
                                    got.idx, got.act, got.last));
            end else begin
                want = act_expected.pop_front();
                if (got.idx !== want.idx)
                    note_fail($sformatf("neuron index expected %0d got %0d",
                                        want.idx, got.idx));
                if (got.act !== want.act)
                    note_fail($sformatf("neuron %0d activation expected %0d got %0d",
                                        want.idx, want.act, got.act));
                if (got.last !== want.last)
                    note_fail($sformatf("neuron %0d last expected %0b got %0b",
                                        want.idx, want.last, got.last));
            end
        end
    end

    // Result side: random ready gaps, one long hold-off once HOLD_AFTER results have arrived.
    initial begin
        int w;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 31) == 0)
                recv_burst = !recv_burst;
            w = recv_burst ? 0 : $urandom_range(0, 19);
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                w = HOLD_CYCLES;
            end
            @(negedge aclk);
            if (w > 0) begin
                m_tready = 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
        end
    end

    // Stimulus: directed plan, then random words.
    initial begin
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_LOAD;
        aresetn      = 1'b0;
        send_burst   = 1'b0;
        elem_pos     = 0;
        for (int n = 0; n < NEURON_COUNT; n++)
            neuron_sum[n] = 0;
        for (int a = 0; a < WEIGHT_DEPTH; a++)
            wt_table[a] = '0;

        // Saturation at the top, ReLU clamp and a load in mid-vector.
        plan[0] = '{ROW_FILL, 7'd0,   16'h7FFF, 0,  1'b0, 31'd0};
        plan[1] = '{ROW_FEAT, 7'd0,   16'h7FFF, 16, 1'b1, 31'h7FFFFFFF};
        plan[2] = '{ROW_FEAT, 7'd0,   16'h8000, 16, 1'b1, 31'd0};
        plan[3] = '{ROW_FEAT, 7'd0,   16'h0100, 3,  1'b0, 31'd0};
        plan[4] = '{ROW_LOAD, 7'd3,   16'hFF00, 0,  1'b0, 31'd0};
        plan[5] = '{ROW_LOAD, 7'd127, 16'h8000, 0,  1'b0, 31'd0};
        plan[6] = '{ROW_FEAT, 7'd0,   16'h0100, 13, 1'b0, 31'd0};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (plan[r]) begin
            case (plan[r].kind)
                ROW_FILL: begin
                    for (int a = 0; a < WEIGHT_DEPTH; a++)
                        send_word(OP_LOAD, ADDR_W'(a), plan[r].val, 1'b0, '0);
                end
                ROW_LOAD: begin
                    send_word(OP_LOAD, plan[r].addr, plan[r].val, 1'b0, '0);
                end
                default: begin
                    for (int k = 0; k < plan[r].count; k++)
                        send_word(OP_FEATURE, ADDR_W'($urandom_range(0, 127)),
                                  plan[r].val, plan[r].fixed, plan[r].fixed_act);
                end
            endcase
        end

        // Random mix of weight updates and feature elements.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS / 2)
                wait_drained();
            if ($urandom_range(0, 4) == 0)
                send_word(OP_LOAD, ADDR_W'($urandom_range(0, 127)), draw_value(), 1'b0, '0);
            else
                send_word(OP_FEATURE, ADDR_W'($urandom_range(0, 127)), draw_value(),
                          1'b0, '0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### dense_layer_relu_core.f
sv/dlr_pkg.sv
sv/dlr_lane.sv
sv/dlr_out.sv
sv/dense_layer_relu_core.sv
sim/dense_layer_relu_core_test.sv
